/* rtl/core/srjt_pkg.sv */
// ============================================================================
// srjt_pkg
// Shared codes, field widths and controller/datapath link types for the
// scan range jump table.
// ============================================================================
package srjt_pkg;

    // Field widths of the item channels
    localparam int RANGE_W = 16;
    localparam int INDEX_W = 10;
    localparam int OUT_W   = 11;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Downward answer when no neighbor exists (-1 in 11 bits)
    localparam logic [OUT_W-1:0] NONE_DOWN = 11'h7FF;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_TAKE,
        OP_INC,
        OP_PIVOT,
        OP_UP,
        OP_DEC,
        OP_DOWN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_go;
        logic up_end;
        logic down_end;
        logic at_zero;
    } t_dp_stat;

endpackage

/* rtl/core/srjt_if.sv */
// ============================================================================
// srjt_in_if / srjt_out_if
// Valid/ready channels carrying input items and result items.
// ============================================================================
interface srjt_in_if;
    logic                          valid;
    logic                          ready;
    logic [srjt_pkg::MODE_W-1:0]   mode;
    logic [srjt_pkg::RANGE_W-1:0]  range;
    logic [srjt_pkg::INDEX_W-1:0]  index;

    modport source (output valid, output mode, output range, output index, input ready);
    modport sink   (input valid, input mode, input range, input index, output ready);
endinterface

interface srjt_out_if;
    logic                               valid;
    logic                               ready;
    logic [srjt_pkg::OUT_W-1:0]         up_smaller;
    logic [srjt_pkg::OUT_W-1:0]         up_larger;
    logic signed [srjt_pkg::OUT_W-1:0]  down_smaller;
    logic signed [srjt_pkg::OUT_W-1:0]  down_larger;
    logic [srjt_pkg::OUT_W-1:0]         point_count;
    logic [srjt_pkg::STAT_W-1:0]        status;

    modport source (output valid, output up_smaller, output up_larger,
                    output down_smaller, output down_larger,
                    output point_count, output status, input ready);
    modport sink   (input valid, input up_smaller, input up_larger,
                    input down_smaller, input down_larger,
                    input point_count, input status, output ready);
endinterface

/* rtl/core/scan_range_jump_table.sv */
// ============================================================================
// scan_range_jump_table
// Stores one scan of 16-bit ranges and answers nearest strictly smaller and
// strictly larger neighbor queries above and below a given index.
//
//   channel   dir   modport   payload
//   i_in      in    sink      mode, range, index
//   o_out     out   source    up/down smaller/larger, point_count, status
//
// Append, clear, unused mode and rejected query pass through the transfer
// state and then the result state.
// A query steps through the transfer state, the pivot fetch (load and pivot
// states) and the upward reads (one read each, up to one past the last entry
// or until both are found). A nonzero index then turns the pointer and makes
// downward reads (down to index 0 at most). The result state comes last. The
// range memory has one write port and one registered read port, giving one
// read per cycle.
// Reset clears the point count and control only; the memory is not cleared.
// A result waiting in the output register does not stall input; a finished
// item waits in its result cycle only while the output register is still full.
// ============================================================================
module scan_range_jump_table #(
    parameter int MAX_POINTS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srjt_in_if.sink       i_in,
    srjt_out_if.source    o_out
);

    srjt_pkg::t_dp_cmd  cmd;
    srjt_pkg::t_dp_stat stat;

    // Sequencer
    srjt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Memory, count and search datapath
    srjt_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_in.mode),
        .i_range        (i_in.range),
        .i_index        (i_in.index),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_up_smaller   (o_out.up_smaller),
        .o_up_larger    (o_out.up_larger),
        .o_down_smaller (o_out.down_smaller),
        .o_down_larger  (o_out.down_larger),
        .o_point_count  (o_out.point_count),
        .o_status       (o_out.status)
    );

endmodule

/* rtl/core/srjt_ctrl.sv */
// ============================================================================
// srjt_ctrl
// Sequencer: takes an item, steps an in-range query through pivot read,
// upward scan and downward scan, then hands the result to the output register.
// ============================================================================
module srjt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  srjt_pkg::t_dp_stat i_stat,
    output srjt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PIVOT,
        S_UP,
        S_DSTART,
        S_DOWN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode state into datapath command and next state
    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd.op       = srjt_pkg::OP_IDLE;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = srjt_pkg::OP_TAKE;
                    n_state  = i_stat.scan_go ? S_LOAD : S_FINISH;
                end
            end
            S_LOAD: begin
                o_cmd.op = srjt_pkg::OP_INC;
                n_state  = S_PIVOT;
            end
            S_PIVOT: begin
                o_cmd.op = srjt_pkg::OP_PIVOT;
                n_state  = S_UP;
            end
            S_UP: begin
                o_cmd.op = srjt_pkg::OP_UP;
                if (i_stat.up_end) begin
                    n_state = i_stat.at_zero ? S_FINISH : S_DSTART;
                end
            end
            S_DSTART: begin
                o_cmd.op = srjt_pkg::OP_DEC;
                n_state  = S_DOWN;
            end
            S_DOWN: begin
                o_cmd.op = srjt_pkg::OP_DOWN;
                if (i_stat.down_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/srjt_dp.sv */
// ============================================================================
// srjt_dp
// Datapath: range memory, point count, scan pointer, neighbor compare and
// result/output registers.
// ============================================================================
module srjt_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [srjt_pkg::MODE_W-1:0]         i_mode,
    input  logic [srjt_pkg::RANGE_W-1:0]        i_range,
    input  logic [srjt_pkg::INDEX_W-1:0]        i_index,
    input  srjt_pkg::t_dp_cmd                   i_cmd,
    output srjt_pkg::t_dp_stat                  o_stat,
    output logic [srjt_pkg::OUT_W-1:0]          o_up_smaller,
    output logic [srjt_pkg::OUT_W-1:0]          o_up_larger,
    output logic signed [srjt_pkg::OUT_W-1:0]   o_down_smaller,
    output logic signed [srjt_pkg::OUT_W-1:0]   o_down_larger,
    output logic [srjt_pkg::OUT_W-1:0]          o_point_count,
    output logic [srjt_pkg::STAT_W-1:0]         o_status
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int PW   = CW + 1;
    localparam int CMPW = CW + srjt_pkg::INDEX_W;

    logic [srjt_pkg::RANGE_W-1:0] r_mem [MAX_POINTS];
    logic [srjt_pkg::RANGE_W-1:0] r_rd_data;
    logic [PW-1:0]                r_rd_idx;
    logic [CW-1:0]                r_count;
    logic [PW-1:0]                r_ptr;
    logic [PW-1:0]                r_at;
    logic [srjt_pkg::RANGE_W-1:0] r_pivot;
    logic                         r_f_us, r_f_ul, r_f_ds, r_f_dl;
    logic [srjt_pkg::OUT_W-1:0]   r_us, r_ul, r_ds, r_dl;
    logic [srjt_pkg::STAT_W-1:0]  r_status;

    logic full;
    logic q_ok;
    logic wr_en;
    logic smaller, larger;
    logic up_past;

    assign full    = (r_count == CW'(MAX_POINTS));
    assign q_ok    = CMPW'(i_index) < CMPW'(r_count);
    assign wr_en   = (i_cmd.op == srjt_pkg::OP_TAKE) && (i_mode == srjt_pkg::MODE_APPEND)
                     && !full;
    assign smaller = r_rd_data < r_pivot;
    assign larger  = r_rd_data > r_pivot;
    assign up_past = r_rd_idx >= PW'(r_count);

    // Status back to the controller
    assign o_stat.scan_go  = (i_mode == srjt_pkg::MODE_QUERY) && q_ok;
    assign o_stat.up_end   = up_past || ((r_f_us || smaller) && (r_f_ul || larger));
    assign o_stat.down_end = (r_rd_idx == '0) || ((r_f_ds || smaller) && (r_f_dl || larger));
    assign o_stat.at_zero  = (r_at == '0);

    // Range memory: one write port, one registered read port at the pointer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_range;
        end
        r_rd_data <= r_mem[r_ptr[AW-1:0]];
        r_rd_idx  <= r_ptr;
    end

    // Point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op == srjt_pkg::OP_TAKE) begin
            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end else if (i_mode == srjt_pkg::MODE_CLEAR) begin
                r_count <= '0;
            end
        end
    end

    // Scan pointer, pivot and neighbor search
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            srjt_pkg::OP_TAKE: begin
                r_us   <= '0;
                r_ul   <= '0;
                r_ds   <= '0;
                r_dl   <= '0;
                r_f_us <= 1'b0;
                r_f_ul <= 1'b0;
                r_f_ds <= 1'b0;
                r_f_dl <= 1'b0;
                r_at   <= PW'(i_index);
                r_ptr  <= PW'(i_index);
                priority if (i_mode == srjt_pkg::MODE_APPEND) begin
                    r_status <= full ? srjt_pkg::ST_FULL : srjt_pkg::ST_OK;
                end else if (i_mode == srjt_pkg::MODE_QUERY) begin
                    if (q_ok) begin
                        r_status <= srjt_pkg::ST_OK;
                        r_us     <= srjt_pkg::OUT_W'(r_count);
                        r_ul     <= srjt_pkg::OUT_W'(r_count);
                        r_ds     <= srjt_pkg::NONE_DOWN;
                        r_dl     <= srjt_pkg::NONE_DOWN;
                    end else begin
                        r_status <= srjt_pkg::ST_RANGE;
                    end
                end else begin
                    r_status <= srjt_pkg::ST_OK;
                end
            end
            srjt_pkg::OP_INC: begin
                r_ptr <= r_ptr + 1'b1;
            end
            srjt_pkg::OP_PIVOT: begin
                r_pivot <= r_rd_data;
                r_ptr   <= r_ptr + 1'b1;
            end
            srjt_pkg::OP_UP: begin
                if (!up_past) begin
                    if (!r_f_us && smaller) begin
                        r_us   <= srjt_pkg::OUT_W'(r_rd_idx);
                        r_f_us <= 1'b1;
                    end
                    if (!r_f_ul && larger) begin
                        r_ul   <= srjt_pkg::OUT_W'(r_rd_idx);
                        r_f_ul <= 1'b1;
                    end
                end
                r_ptr <= o_stat.up_end ? (r_at - 1'b1) : (r_ptr + 1'b1);
            end
            srjt_pkg::OP_DEC: begin
                r_ptr <= r_ptr - 1'b1;
            end
            srjt_pkg::OP_DOWN: begin
                if (!r_f_ds && smaller) begin
                    r_ds   <= srjt_pkg::OUT_W'(r_rd_idx);
                    r_f_ds <= 1'b1;
                end
                if (!r_f_dl && larger) begin
                    r_dl   <= srjt_pkg::OUT_W'(r_rd_idx);
                    r_f_dl <= 1'b1;
                end
                r_ptr <= r_ptr - 1'b1;
            end
            srjt_pkg::OP_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_up_smaller   <= r_us;
            o_up_larger    <= r_ul;
            o_down_smaller <= r_ds;
            o_down_larger  <= r_dl;
            o_point_count  <= srjt_pkg::OUT_W'(r_count);
            o_status       <= r_status;
        end
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for scan_range_jump_table
// Sends append, query, clear and unused-mode items over the input channel.
// Each transfer is predicted by a local model of the range store, and each
// result is checked field by field against the oldest prediction. Both
// channels idle at random, and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                         STORE_DEPTH = 1024;
    localparam logic [srjt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                         HOLD_CYCLES = 400;

    typedef logic [srjt_pkg::RANGE_W-1:0] t_range;
    typedef logic [srjt_pkg::INDEX_W-1:0] t_index;

    typedef struct packed {
        logic [srjt_pkg::MODE_W-1:0]  mode;
        logic [srjt_pkg::RANGE_W-1:0] range;
        logic [srjt_pkg::INDEX_W-1:0] index;
    } t_scan_item;

    typedef struct packed {
        logic [srjt_pkg::OUT_W-1:0]  up_smaller;
        logic [srjt_pkg::OUT_W-1:0]  up_larger;
        logic [srjt_pkg::OUT_W-1:0]  down_smaller;
        logic [srjt_pkg::OUT_W-1:0]  down_larger;
        logic [srjt_pkg::OUT_W-1:0]  point_count;
        logic [srjt_pkg::STAT_W-1:0] status;
    } t_neighbor_answer;

    logic i_clk;
    logic i_rst_n;

    srjt_in_if  in_if ();
    srjt_out_if out_if ();

    scan_range_jump_table #(
        .MAX_POINTS(STORE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Items waiting to go out, answers waiting to come back
    t_scan_item       items_to_send[$];
    t_neighbor_answer answers_due[$];

    // Local copy of the range store
    logic [srjt_pkg::RANGE_W-1:0] scan_ranges [STORE_DEPTH];
    int                           held_count;

    int errors;
    int items_sent;
    int results_seen;
    int gen_count;
    int send_gap;
    int stall_left;
    int hold_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one transfer to the local store and work out its answer
    function automatic t_neighbor_answer predict_neighbors(t_scan_item it);
        t_neighbor_answer             a;
        logic [srjt_pkg::RANGE_W-1:0] pivot;
        bit                           f_us, f_ul, f_ds, f_dl;
        int                           us, ul, ds, dl;
        a = '0;
        case (it.mode)
            srjt_pkg::MODE_APPEND: begin
                if (held_count < STORE_DEPTH) begin
                    scan_ranges[held_count[srjt_pkg::INDEX_W-1:0]] = it.range;
                    held_count++;
                end else begin
                    a.status = srjt_pkg::ST_FULL;
                end
            end
            srjt_pkg::MODE_QUERY: begin
                if (int'(it.index) < held_count) begin
                    pivot = scan_ranges[it.index];
                    us = held_count;
                    ul = held_count;
                    ds = -1;
                    dl = -1;
                    f_us = 0; f_ul = 0; f_ds = 0; f_dl = 0;
                    // walk upward until both neighbors found
                    for (int j = int'(it.index) + 1; j < held_count && !(f_us && f_ul);
                         j++) begin
                        if (!f_us && scan_ranges[j[srjt_pkg::INDEX_W-1:0]] < pivot) begin
                            us = j;
                            f_us = 1;
                        end
                        if (!f_ul && scan_ranges[j[srjt_pkg::INDEX_W-1:0]] > pivot) begin
                            ul = j;
                            f_ul = 1;
                        end
                    end
                    // walk downward the same way
                    for (int j = int'(it.index) - 1; j >= 0 && !(f_ds && f_dl); j--) begin
                        if (!f_ds && scan_ranges[j[srjt_pkg::INDEX_W-1:0]] < pivot) begin
                            ds = j;
                            f_ds = 1;
                        end
                        if (!f_dl && scan_ranges[j[srjt_pkg::INDEX_W-1:0]] > pivot) begin
                            dl = j;
                            f_dl = 1;
                        end
                    end
                    a.up_smaller   = us[srjt_pkg::OUT_W-1:0];
                    a.up_larger    = ul[srjt_pkg::OUT_W-1:0];
                    a.down_smaller = f_ds ? ds[srjt_pkg::OUT_W-1:0] : srjt_pkg::NONE_DOWN;
                    a.down_larger  = f_dl ? dl[srjt_pkg::OUT_W-1:0] : srjt_pkg::NONE_DOWN;
                end else begin
                    a.status = srjt_pkg::ST_RANGE;
                end
            end
            srjt_pkg::MODE_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        a.point_count = held_count[srjt_pkg::OUT_W-1:0];
        return a;
    endfunction

    // Queue one item and track the count it leaves behind
    task automatic queue_item(logic [srjt_pkg::MODE_W-1:0] mode, t_range range,
                              t_index index);
        t_scan_item it;
        it.mode  = mode;
        it.range = range;
        it.index = index;
        items_to_send.insert(items_to_send.size(), it);
        if (mode == srjt_pkg::MODE_APPEND && gen_count < STORE_DEPTH)
            gen_count++;
        else if (mode == srjt_pkg::MODE_CLEAR)
            gen_count = 0;
    endtask

    task automatic report_mismatch(string field, logic [srjt_pkg::OUT_W-1:0] got,
                                   logic [srjt_pkg::OUT_W-1:0] want);
        $display("[%0t] result %0d: %s got %0d expected %0d",
                 $realtime, results_seen, field, got, want);
        errors++;
    endtask

    task automatic check_field(string field, logic [srjt_pkg::OUT_W-1:0] got,
                               logic [srjt_pkg::OUT_W-1:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // Driver: present items, predict each transfer
    always @(posedge i_clk) begin : driver
        t_scan_item       nxt;
        t_scan_item       took;
        t_neighbor_answer due;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                took.mode  = in_if.mode;
                took.range = in_if.range;
                took.index = in_if.index;
                due = predict_neighbors(took);
                answers_due.insert(answers_due.size(), due);
                items_sent <= items_sent + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap != 0) begin
                    in_if.valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end else if (items_to_send.size() != 0) begin
                    nxt = items_to_send.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.mode  <= nxt.mode;
                    in_if.range <= nxt.range;
                    in_if.index <= nxt.index;
                    // quiet stretches with back-to-back items
                    send_gap <= ((items_sent % 160) < 40) ? 0 : $urandom_range(0, 5);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (out_if.valid && out_if.ready && (results_seen == 120 || results_seen == 400))
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check each result, draw the next stall
    always @(posedge i_clk) begin : monitor
        t_neighbor_answer want;
        int               s;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            s = stall_left;
            if (out_if.valid && out_if.ready) begin
                if (answers_due.size() == 0) begin
                    $display("[%0t] result %0d arrived with nothing expected",
                             $realtime, results_seen);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("up_smaller", out_if.up_smaller, want.up_smaller);
                    check_field("up_larger", out_if.up_larger, want.up_larger);
                    check_field("down_smaller", out_if.down_smaller, want.down_smaller);
                    check_field("down_larger", out_if.down_larger, want.down_larger);
                    check_field("point_count", out_if.point_count, want.point_count);
                    check_field("status",
                                {{(srjt_pkg::OUT_W-srjt_pkg::STAT_W){1'b0}}, out_if.status},
                                {{(srjt_pkg::OUT_W-srjt_pkg::STAT_W){1'b0}}, want.status});
                end
                results_seen <= results_seen + 1;
                s = ((results_seen % 200) < 50) ? 0 : $urandom_range(0, 5);
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
            end else if (s != 0) begin
                out_if.ready <= 1'b0;
                s--;
            end else begin
                out_if.ready <= 1'b1;
            end
            stall_left <= s;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int     n_app, n_qry, style, room;
        t_range base, step;
        t_index idx;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.mode   = srjt_pkg::MODE_APPEND;
        in_if.range  = '0;
        in_if.index  = '0;
        out_if.ready = 1'b0;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        gen_count    = 0;
        held_count   = 0;
        foreach (scan_ranges[k])
            scan_ranges[k] = '0;

        // Directed: empty store, extremes, equal values, unused mode
        queue_item(srjt_pkg::MODE_QUERY, 16'h0000, 10'd0);
        queue_item(srjt_pkg::MODE_QUERY, 16'hFFFF, 10'd1023);
        queue_item(MODE_UNUSED, 16'hFFFF, 10'h3FF);
        queue_item(srjt_pkg::MODE_CLEAR, 16'h0000, 10'd0);
        queue_item(srjt_pkg::MODE_APPEND, 16'h0000, 10'h3FF);
        queue_item(srjt_pkg::MODE_APPEND, 16'hFFFF, 10'd0);
        queue_item(srjt_pkg::MODE_APPEND, 16'h8000, 10'd0);
        queue_item(srjt_pkg::MODE_APPEND, 16'hFFFF, 10'd0);
        queue_item(srjt_pkg::MODE_APPEND, 16'h0001, 10'd0);
        queue_item(srjt_pkg::MODE_APPEND, 16'h8000, 10'd0);
        for (int k = 0; k < 6; k++)
            queue_item(srjt_pkg::MODE_QUERY, 16'h0000, k[srjt_pkg::INDEX_W-1:0]);
        queue_item(srjt_pkg::MODE_QUERY, 16'h0000, 10'd6);
        queue_item(srjt_pkg::MODE_QUERY, 16'h0000, 10'd1023);
        queue_item(MODE_UNUSED, 16'h1234, 10'd2);
        queue_item(srjt_pkg::MODE_QUERY, 16'h0000, 10'd3);
        queue_item(srjt_pkg::MODE_CLEAR, 16'hFFFF, 10'h3FF);
        queue_item(srjt_pkg::MODE_QUERY, 16'h0000, 10'd0);

        // Random: fill-then-query sequences
        while (items_to_send.size() < 570) begin
            if ($urandom_range(0, 4) != 0)
                queue_item(srjt_pkg::MODE_CLEAR, t_range'($urandom), t_index'($urandom));
            n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 24);
            // keep the run near its planned length
            room = 575 - int'(items_to_send.size());
            if (n_app > room)
                n_app = room;
            style = $urandom_range(0, 3);
            base  = t_range'($urandom);
            step  = t_range'($urandom_range(1, 300));
            for (int k = 0; k < n_app; k++) begin
                case (style)
                    0: queue_item(srjt_pkg::MODE_APPEND, t_range'($urandom),
                                  t_index'($urandom));
                    1: queue_item(srjt_pkg::MODE_APPEND, t_range'(base + $urandom_range(0, 3)),
                                  t_index'($urandom));
                    2: queue_item(srjt_pkg::MODE_APPEND, t_range'(base + k * step),
                                  t_index'($urandom));
                    default: queue_item(srjt_pkg::MODE_APPEND, t_range'(base - k * step),
                                        t_index'($urandom));
                endcase
            end
            n_qry = $urandom_range(2, 10);
            for (int k = 0; k < n_qry; k++) begin
                case ($urandom_range(0, 11))
                    0: queue_item(MODE_UNUSED, t_range'($urandom), t_index'($urandom));
                    1: queue_item(srjt_pkg::MODE_APPEND, t_range'($urandom),
                                  t_index'($urandom));
                    2: begin
                        // index at or past the count
                        idx = (gen_count < STORE_DEPTH) ?
                              t_index'($urandom_range(gen_count, STORE_DEPTH - 1)) :
                              t_index'($urandom);
                        if (gen_count < STORE_DEPTH)
                            queue_item(srjt_pkg::MODE_QUERY, t_range'($urandom), idx);
                        else
                            queue_item(MODE_UNUSED, t_range'($urandom), idx);
                    end
                    default: begin
                        if (gen_count > 0)
                            queue_item(srjt_pkg::MODE_QUERY, t_range'($urandom),
                                       t_index'($urandom_range(0, gen_count - 1)));
                        else
                            queue_item(srjt_pkg::MODE_QUERY, t_range'($urandom),
                                       t_index'($urandom));
                    end
                endcase
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_to_send.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0)
            $display("scan_range_jump_table verification clean");
        else
            $display("scan_range_jump_table verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("scan_range_jump_table verification failed");
        $finish;
    end

endmodule

/* scan_range_jump_table.f */
rtl/core/srjt_pkg.sv
rtl/core/srjt_if.sv
rtl/core/srjt_ctrl.sv
rtl/core/srjt_dp.sv
rtl/core/scan_range_jump_table.sv
test/tb.sv
